@@ src/hsvrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types, constants and helpers shared by the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

	localparam int HUE_W = 12;
	localparam int PCT_W = 7;
	localparam int DIST_W = 10;
	localparam int SV_W = 14;
	localparam int NUM_W = 23;
	localparam int PROD17_W = 28;
	localparam int QUO_W = 21;
	localparam int RECIP_W = 21;
	localparam int MUL_W = QUO_W + RECIP_W;
	localparam int CH_W = 8;
	localparam int RECIP_SHIFT = 32;
	localparam int DIV_SHIFT = 7;

	localparam logic [HUE_W-1:0] HUE_MAX = 12'd3600;
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
	localparam logic [DIST_W-1:0] SECTOR_TENTHS = 10'd600;
	localparam logic [15:0] V_SCALE = 16'd60000;
	// ceil(2^32 / 3125): exact floor division for quotients below 2^21
	localparam logic [RECIP_W-1:0] RECIP_3125 = 21'd1374390;

	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	typedef struct packed {
		logic    vld;
		logic    err;
		sector_t sector;
	} ctl_t;

	function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
		logic [HUE_W-1:0] base;
		case (sec)
			SEC_RY: base = 12'd0;
			SEC_YG: base = 12'd600;
			SEC_GC: base = 12'd1200;
			SEC_CB: base = 12'd1800;
			SEC_BM: base = 12'd2400;
			SEC_MR: base = 12'd3000;
			default: base = 12'd3000;
		endcase
		return base;
	endfunction

endpackage

`default_nettype wire

@@ src/hsvrgb_front.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_front
// Stage 1: range check, hue sector select and distance to the secondary peak.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_vld,
	input  wire logic [hsvrgb_pkg::HUE_W-1:0]    hue,
	input  wire logic [hsvrgb_pkg::PCT_W-1:0]    sat,
	input  wire logic [hsvrgb_pkg::PCT_W-1:0]    val,
	output hsvrgb_pkg::ctl_t                     ctl_s1,
	output logic      [hsvrgb_pkg::DIST_W-1:0]   dist_s1,
	output logic      [hsvrgb_pkg::PCT_W-1:0]    sat_s1,
	output logic      [hsvrgb_pkg::PCT_W-1:0]    val_s1
);

	hsvrgb_pkg::sector_t sec;
	logic [hsvrgb_pkg::HUE_W-1:0] offs;
	logic [hsvrgb_pkg::DIST_W-1:0] hue_dist;
	logic err;

	always_comb begin
		if (hue < 12'd600) begin
			sec = hsvrgb_pkg::SEC_RY;
		end else if (hue < 12'd1200) begin
			sec = hsvrgb_pkg::SEC_YG;
		end else if (hue < 12'd1800) begin
			sec = hsvrgb_pkg::SEC_GC;
		end else if (hue < 12'd2400) begin
			sec = hsvrgb_pkg::SEC_CB;
		end else if (hue < 12'd3000) begin
			sec = hsvrgb_pkg::SEC_BM;
		end else begin
			sec = hsvrgb_pkg::SEC_MR;
		end
		offs = hue - hsvrgb_pkg::sector_base(sec);
		if (sec == hsvrgb_pkg::SEC_RY || sec == hsvrgb_pkg::SEC_GC ||
				sec == hsvrgb_pkg::SEC_BM) begin
			hue_dist = hsvrgb_pkg::SECTOR_TENTHS - offs[hsvrgb_pkg::DIST_W-1:0];
		end else begin
			hue_dist = offs[hsvrgb_pkg::DIST_W-1:0];
		end
		err = (hue > hsvrgb_pkg::HUE_MAX) || (sat > hsvrgb_pkg::PCT_MAX) ||
			(val > hsvrgb_pkg::PCT_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= '{vld: in_vld, err: err, sector: sec};
		end
	end

	always_ff @(posedge clk) begin
		dist_s1       <= hue_dist;
		sat_s1        <= sat;
		val_s1        <= val;
	end

endmodule

`default_nettype wire

@@ src/hsvrgb_chroma.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_chroma
// Stages 2 and 3: chroma, secondary and offset numerators, full scale 6000000.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_chroma (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire hsvrgb_pkg::ctl_t                ctl_s1,
	input  wire logic [hsvrgb_pkg::DIST_W-1:0]   dist_s1,
	input  wire logic [hsvrgb_pkg::PCT_W-1:0]    sat_s1,
	input  wire logic [hsvrgb_pkg::PCT_W-1:0]    val_s1,
	output hsvrgb_pkg::ctl_t                     ctl_s3,
	output logic      [hsvrgb_pkg::NUM_W-1:0]    nc_s3,
	output logic      [hsvrgb_pkg::NUM_W-1:0]    nx_s3,
	output logic      [hsvrgb_pkg::NUM_W-1:0]    nz_s3
);

	hsvrgb_pkg::ctl_t ctl_s2;
	logic [hsvrgb_pkg::SV_W-1:0]   sv_s2;
	logic [hsvrgb_pkg::NUM_W-1:0]  vfull_s2;
	logic [hsvrgb_pkg::DIST_W-1:0] dist_s2;
	logic [hsvrgb_pkg::NUM_W-1:0]  svd;
	logic [hsvrgb_pkg::NUM_W-1:0]  svc;

	assign svd = hsvrgb_pkg::NUM_W'(sv_s2) * hsvrgb_pkg::NUM_W'(dist_s2);
	assign svc = hsvrgb_pkg::NUM_W'(sv_s2) * hsvrgb_pkg::NUM_W'(hsvrgb_pkg::SECTOR_TENTHS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		sv_s2         <= hsvrgb_pkg::SV_W'(sat_s1) * hsvrgb_pkg::SV_W'(val_s1);
		vfull_s2      <= hsvrgb_pkg::NUM_W'(val_s1) * hsvrgb_pkg::NUM_W'(hsvrgb_pkg::V_SCALE);
		dist_s2       <= dist_s1;

		nc_s3         <= vfull_s2;
		nx_s3         <= vfull_s2 - svd;
		nz_s3         <= vfull_s2 - svc;
	end

endmodule

`default_nettype wire

@@ src/hsvrgb_div.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_div
// Stages 4 and 5: channel = floor(17 * n / 400000) by shift and reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_div (
	input  wire logic                            clk,
	input  wire logic                            err_s3,
	input  wire logic [hsvrgb_pkg::NUM_W-1:0]    num_s3,
	output logic      [hsvrgb_pkg::CH_W-1:0]     ch_s5
);

	logic [hsvrgb_pkg::PROD17_W-1:0] p17;
	logic [hsvrgb_pkg::QUO_W-1:0]    quo_s4;
	logic                            err_s4;
	logic [hsvrgb_pkg::MUL_W-1:0]    prod;

	assign p17  = {1'b0, num_s3, 4'd0} + hsvrgb_pkg::PROD17_W'(num_s3);
	assign prod = hsvrgb_pkg::MUL_W'(quo_s4) * hsvrgb_pkg::MUL_W'(hsvrgb_pkg::RECIP_3125);

	always_ff @(posedge clk) begin
		quo_s4 <= p17[hsvrgb_pkg::PROD17_W-1:hsvrgb_pkg::DIV_SHIFT];
		err_s4 <= err_s3;
		if (err_s4) begin
			ch_s5 <= '0;
		end else begin
			ch_s5 <= prod[hsvrgb_pkg::RECIP_SHIFT +: hsvrgb_pkg::CH_W];
		end
	end

endmodule

`default_nettype wire

@@ src/hsv_to_rgb_converter_top.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV (tenths of a degree, percent) to 8-bit RGB converter, five-stage pipeline.
// ----------------------------------------------------------------------------
// An accepted start leaves the last stage with the done strobe and its result.
// Throughput: one transaction per cycle; busy is always low.
// Results are not held: done marks each result for exactly one cycle.
// Reset clears the stage valid bits and the done and range_error outputs.
`default_nettype none

module hsv_to_rgb_converter_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [hsvrgb_pkg::HUE_W-1:0]    hue_tenths,
	input  wire logic [hsvrgb_pkg::PCT_W-1:0]    saturation_pct,
	input  wire logic [hsvrgb_pkg::PCT_W-1:0]    value_pct,
	output logic                                 done,
	output logic      [hsvrgb_pkg::CH_W-1:0]     red,
	output logic      [hsvrgb_pkg::CH_W-1:0]     green,
	output logic      [hsvrgb_pkg::CH_W-1:0]     blue,
	output logic                                 range_error
);

	hsvrgb_pkg::ctl_t ctl_s1;
	hsvrgb_pkg::ctl_t ctl_s3;
	logic [hsvrgb_pkg::DIST_W-1:0] dist_s1;
	logic [hsvrgb_pkg::PCT_W-1:0]  sat_s1;
	logic [hsvrgb_pkg::PCT_W-1:0]  val_s1;
	logic [hsvrgb_pkg::NUM_W-1:0]  nc_s3;
	logic [hsvrgb_pkg::NUM_W-1:0]  nx_s3;
	logic [hsvrgb_pkg::NUM_W-1:0]  nz_s3;
	logic [hsvrgb_pkg::NUM_W-1:0]  nr;
	logic [hsvrgb_pkg::NUM_W-1:0]  ng;
	logic [hsvrgb_pkg::NUM_W-1:0]  nb;
	logic                          vld_s4;
	logic                          err_s4;

	assign busy = 1'b0;

	hsvrgb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.hue     (hue_tenths),
		.sat     (saturation_pct),
		.val     (value_pct),
		.ctl_s1  (ctl_s1),
		.dist_s1 (dist_s1),
		.sat_s1  (sat_s1),
		.val_s1  (val_s1)
	);

	hsvrgb_chroma u_chroma (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.dist_s1 (dist_s1),
		.sat_s1  (sat_s1),
		.val_s1  (val_s1),
		.ctl_s3  (ctl_s3),
		.nc_s3   (nc_s3),
		.nx_s3   (nx_s3),
		.nz_s3   (nz_s3)
	);

	// route chroma, secondary and offset-only terms to channels
	always_comb begin
		case (ctl_s3.sector)
			hsvrgb_pkg::SEC_RY: begin
				nr = nc_s3; ng = nx_s3; nb = nz_s3;
			end
			hsvrgb_pkg::SEC_YG: begin
				nr = nx_s3; ng = nc_s3; nb = nz_s3;
			end
			hsvrgb_pkg::SEC_GC: begin
				nr = nz_s3; ng = nc_s3; nb = nx_s3;
			end
			hsvrgb_pkg::SEC_CB: begin
				nr = nz_s3; ng = nx_s3; nb = nc_s3;
			end
			hsvrgb_pkg::SEC_BM: begin
				nr = nx_s3; ng = nz_s3; nb = nc_s3;
			end
			default: begin
				nr = nc_s3; ng = nz_s3; nb = nx_s3;
			end
		endcase
	end

	hsvrgb_div u_div_r (
		.clk    (clk),
		.err_s3 (ctl_s3.err),
		.num_s3 (nr),
		.ch_s5  (red)
	);

	hsvrgb_div u_div_g (
		.clk    (clk),
		.err_s3 (ctl_s3.err),
		.num_s3 (ng),
		.ch_s5  (green)
	);

	hsvrgb_div u_div_b (
		.clk    (clk),
		.err_s3 (ctl_s3.err),
		.num_s3 (nb),
		.ch_s5  (blue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4      <= 1'b0;
			err_s4      <= 1'b0;
			done        <= 1'b0;
			range_error <= 1'b0;
		end else begin
			vld_s4      <= ctl_s3.vld;
			err_s4      <= ctl_s3.err;
			done        <= vld_s4;
			range_error <= vld_s4 && err_s4;
		end
	end

endmodule

`default_nettype wire

@@ src/hsvrgb_checker.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks on result timing and the range error flag.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            start,
	input wire logic                            busy,
	input wire logic [hsvrgb_pkg::HUE_W-1:0]    hue_tenths,
	input wire logic [hsvrgb_pkg::PCT_W-1:0]    saturation_pct,
	input wire logic [hsvrgb_pkg::PCT_W-1:0]    value_pct,
	input wire logic                            done,
	input wire logic [hsvrgb_pkg::CH_W-1:0]     red,
	input wire logic [hsvrgb_pkg::CH_W-1:0]     green,
	input wire logic [hsvrgb_pkg::CH_W-1:0]     blue,
	input wire logic                            range_error
);

	logic bad_in;

	assign bad_in = (hue_tenths > hsvrgb_pkg::HUE_MAX) ||
		(saturation_pct > hsvrgb_pkg::PCT_MAX) || (value_pct > hsvrgb_pkg::PCT_MAX);

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("done without a transaction accepted five cycles earlier");

	a_err_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		range_error |-> done)
		else $error("range_error outside a result cycle");

	a_err_zero_rgb: assert property (@(posedge clk) disable iff (!arst_n)
		range_error |-> (red == '0 && green == '0 && blue == '0))
		else $error("nonzero channel on a range error");

	a_err_matches_input: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (range_error == $past(bad_in, 5)))
		else $error("range_error does not match the accepted input");

endmodule

bind hsv_to_rgb_converter_top hsvrgb_checker u_hsvrgb_checker (.*);

`default_nettype wire

@@ tb/hsv_to_rgb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// Watches the command and result channels of the HSV to RGB converter. It
// predicts each accepted pixel's RGB value and range flag from its own exact
// integer model, and compares every done strobe with the oldest prediction.
// ----------------------------------------------------------------------------

module hsv_to_rgb_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [hsvrgb_pkg::HUE_W-1:0] hue_tenths,
	input  logic [hsvrgb_pkg::PCT_W-1:0] saturation_pct,
	input  logic [hsvrgb_pkg::PCT_W-1:0] value_pct,
	input  logic                         done,
	input  logic [hsvrgb_pkg::CH_W-1:0]  red,
	input  logic [hsvrgb_pkg::CH_W-1:0]  green,
	input  logic [hsvrgb_pkg::CH_W-1:0]  blue,
	input  logic                         range_error,
	output int                           fail_count,
	output int                           pending,
	output int                           checked,
	output int                           flagged
);

	localparam longint unsigned FULL_SCALE = 255;
	localparam longint unsigned SECTOR_SPAN = 600;
	localparam longint unsigned DENOM = 6000000;

	typedef struct packed {
		logic [hsvrgb_pkg::CH_W-1:0] r;
		logic [hsvrgb_pkg::CH_W-1:0] g;
		logic [hsvrgb_pkg::CH_W-1:0] b;
		logic                        err;
	} rgb_t;

	rgb_t rgb_expected[$];

	assign pending = rgb_expected.size();

	function automatic rgb_t convert_hsv(input logic [hsvrgb_pkg::HUE_W-1:0] h,
			input logic [hsvrgb_pkg::PCT_W-1:0] s, input logic [hsvrgb_pkg::PCT_W-1:0] v);
		longint unsigned hh, ss, vv, cn, xn, mn, t, hdist, rn, gn, bn;
		hsvrgb_pkg::sector_t sec;
		rgb_t px;
		hh = h;
		ss = s;
		vv = v;
		px = '0;
		if (h > hsvrgb_pkg::HUE_MAX || s > hsvrgb_pkg::PCT_MAX ||
				v > hsvrgb_pkg::PCT_MAX) begin
			px.err = 1'b1;
			return px;
		end
		cn = ss * vv * FULL_SCALE * SECTOR_SPAN;
		t = hh % (2 * SECTOR_SPAN);
		hdist = (t >= SECTOR_SPAN) ? (t - SECTOR_SPAN) : (SECTOR_SPAN - t);
		xn = ss * vv * FULL_SCALE * (SECTOR_SPAN - hdist);
		mn = vv * FULL_SCALE * (100 - ss) * SECTOR_SPAN;
		sec = (hh / SECTOR_SPAN > 5) ? hsvrgb_pkg::SEC_MR :
			hsvrgb_pkg::sector_t'(hh / SECTOR_SPAN);
		case (sec)
			hsvrgb_pkg::SEC_RY: begin rn = cn; gn = xn; bn = 0; end
			hsvrgb_pkg::SEC_YG: begin rn = xn; gn = cn; bn = 0; end
			hsvrgb_pkg::SEC_GC: begin rn = 0; gn = cn; bn = xn; end
			hsvrgb_pkg::SEC_CB: begin rn = 0; gn = xn; bn = cn; end
			hsvrgb_pkg::SEC_BM: begin rn = xn; gn = 0; bn = cn; end
			default: begin rn = cn; gn = 0; bn = xn; end
		endcase
		px.r = hsvrgb_pkg::CH_W'((rn + mn) / DENOM);
		px.g = hsvrgb_pkg::CH_W'((gn + mn) / DENOM);
		px.b = hsvrgb_pkg::CH_W'((bn + mn) / DENOM);
		return px;
	endfunction

	initial begin
		fail_count = 0;
		checked = 0;
		flagged = 0;
	end

	always @(posedge clk) begin
		rgb_t want;
		rgb_t got;
		if (arst_n) begin
			if (start && !busy)
				rgb_expected.push_back(convert_hsv(hue_tenths, saturation_pct, value_pct));
			if (done) begin
				got = '{r: red, g: green, b: blue, err: range_error};
				if (rgb_expected.size() == 0) begin
					$display("%0t: unexpected result r=%0d g=%0d b=%0d err=%0b",
						$time, red, green, blue, range_error);
					fail_count <= fail_count + 1;
				end else begin
					want = rgb_expected.pop_front();
					checked <= checked + 1;
					if (want.err)
						flagged <= flagged + 1;
					if (got.r !== want.r || got.g !== want.g || got.b !== want.b ||
							got.err !== want.err) begin
						$display({"%0t: mismatch expected r=%0d g=%0d b=%0d err=%0b,",
							" actual r=%0d g=%0d b=%0d err=%0b"},
							$time, want.r, want.g, want.b, want.err,
							got.r, got.g, got.b, got.err);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

@@ tb/tb_hsv_to_rgb_converter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_top
// Drives directed corner pixels, then random pixels (mostly in range, some out
// of range over the full field widths) into the converter with random gaps,
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------

module tb_hsv_to_rgb_converter_top;

	localparam int RANDOM_ITEMS = 700;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [hsvrgb_pkg::HUE_W-1:0] hue_tenths;
	logic [hsvrgb_pkg::PCT_W-1:0] saturation_pct;
	logic [hsvrgb_pkg::PCT_W-1:0] value_pct;
	logic                         done;
	logic [hsvrgb_pkg::CH_W-1:0]  red;
	logic [hsvrgb_pkg::CH_W-1:0]  green;
	logic [hsvrgb_pkg::CH_W-1:0]  blue;
	logic                         range_error;

	int fail_count;
	int pending;
	int checked;
	int flagged;
	int cycles;
	bit quiet_run;

	hsv_to_rgb_converter_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.hue_tenths     (hue_tenths),
		.saturation_pct (saturation_pct),
		.value_pct      (value_pct),
		.done           (done),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.range_error    (range_error)
	);

	hsv_to_rgb_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.hue_tenths     (hue_tenths),
		.saturation_pct (saturation_pct),
		.value_pct      (value_pct),
		.done           (done),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.range_error    (range_error),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked        (checked),
		.flagged        (flagged)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("hsv_to_rgb_converter_top test failed");
			$finish;
		end
	end

	task automatic send_pixel(input logic [hsvrgb_pkg::HUE_W-1:0] h,
			input logic [hsvrgb_pkg::PCT_W-1:0] s, input logic [hsvrgb_pkg::PCT_W-1:0] v);
		if (!quiet_run && $urandom_range(99) < 16) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 16);
		end
		start <= 1'b1;
		hue_tenths <= h;
		saturation_pct <= s;
		value_pct <= v;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic send_random_pixel();
		logic [hsvrgb_pkg::HUE_W-1:0] h;
		logic [hsvrgb_pkg::PCT_W-1:0] s;
		logic [hsvrgb_pkg::PCT_W-1:0] v;
		int pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			h = hsvrgb_pkg::HUE_W'($urandom());
			s = hsvrgb_pkg::PCT_W'($urandom());
			v = hsvrgb_pkg::PCT_W'($urandom());
		end else if (pick < 25) begin
			h = hsvrgb_pkg::HUE_W'(600 * $urandom_range(6) + $urandom_range(2) - 1);
			if (h > hsvrgb_pkg::HUE_MAX)
				h = hsvrgb_pkg::HUE_MAX;
			s = $urandom_range(1) ? hsvrgb_pkg::PCT_MAX : '0;
			v = $urandom_range(1) ? hsvrgb_pkg::PCT_MAX :
				hsvrgb_pkg::PCT_W'($urandom_range(100));
		end else begin
			h = hsvrgb_pkg::HUE_W'($urandom_range(3600));
			s = hsvrgb_pkg::PCT_W'($urandom_range(100));
			v = hsvrgb_pkg::PCT_W'($urandom_range(100));
		end
		send_pixel(h, s, v);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		hue_tenths = '0;
		saturation_pct = '0;
		value_pct = '0;
		quiet_run = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(12'd0, 7'd0, 7'd0);
		send_pixel(12'd0, 7'd100, 7'd100);
		send_pixel(12'd300, 7'd100, 7'd100);
		send_pixel(12'd599, 7'd100, 7'd100);
		send_pixel(12'd600, 7'd100, 7'd100);
		send_pixel(12'd1200, 7'd100, 7'd100);
		send_pixel(12'd1800, 7'd50, 7'd50);
		send_pixel(12'd2400, 7'd100, 7'd100);
		send_pixel(12'd3000, 7'd100, 7'd100);
		send_pixel(12'd3599, 7'd100, 7'd100);
		send_pixel(12'd3600, 7'd100, 7'd100);
		send_pixel(12'd3600, 7'd0, 7'd100);
		send_pixel(12'd2047, 7'd63, 7'd64);
		send_pixel(12'd3601, 7'd50, 7'd50);
		send_pixel(12'd4095, 7'd127, 7'd127);
		send_pixel(12'd0, 7'd101, 7'd50);
		send_pixel(12'd0, 7'd50, 7'd101);
		send_pixel(12'd900, 7'd127, 7'd0);
		send_pixel(12'd4095, 7'd0, 7'd0);
		send_pixel(12'd1500, 7'd1, 7'd1);
		send_pixel(12'd2700, 7'd99, 7'd37);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet_run = (i >= 250 && i < 400);
			if (i == 500) begin
				start <= 1'b0;
				do
					@(posedge clk);
				while (pending != 0);
			end
			send_random_pixel();
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d converted pixels, %0d of them flagged out of range,",
			checked, flagged);
		$display("covering all six hue sectors, boundaries and full-width field values.");
		if (fail_count == 0 && pending == 0) begin
			$display("hsv_to_rgb_converter_top test passed");
		end else begin
			$display("hsv_to_rgb_converter_top test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/hsvrgb_pkg.sv
src/hsvrgb_front.sv
src/hsvrgb_chroma.sv
src/hsvrgb_div.sv
src/hsv_to_rgb_converter_top.sv
src/hsvrgb_checker.sv
tb/hsv_to_rgb_checker.sv
tb/tb_hsv_to_rgb_converter_top.sv
